@@ rtl/core/ppmsf_pkg.sv @@
// Shared types and constants for the PPM-sum frame decoder.
`default_nettype none

package ppmsf_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd4;

    localparam logic [15:0] SYNC_LOW_RST   = 16'd3000;
    localparam logic [15:0] SYNC_HIGH_RST  = 16'd21000;
    localparam logic [15:0] VALID_LOW_RST  = 16'd900;
    localparam logic [15:0] VALID_HIGH_RST = 16'd2200;
    localparam logic [3:0]  CHANNELS_RST   = 4'd8;
    localparam logic [15:0] SLOT_RST_VALUE = 16'd1500;

    localparam logic [3:0]  CNT_MAX = 4'd15;

    typedef enum logic {
        CMD_EDGE = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [15:0] sync_low;
        logic [15:0] sync_high;
        logic [15:0] valid_low;
        logic [15:0] valid_high;
        logic [3:0]  channels;
    } t_cfg;

    typedef struct packed {
        logic        en;
        logic [3:0]  slot;
        logic [15:0] data;
    } t_slot_wr;

    typedef struct packed {
        logic [15:0] value;
        logic [3:0]  pulses;
        logic        synced;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/core/ppmsf_slot_ram.sv @@
// Slot store: synchronous RAM with per-entry valid bits for the reset value.
`default_nettype none

module ppmsf_slot_ram #(
    parameter int unsigned SLOT_COUNT = 12
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ppmsf_pkg::t_slot_wr i_wr,
    input  wire                 i_re,
    input  wire  [3:0]          i_raddr,
    output logic [15:0]         o_rdata
);

    localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [15:0]           r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;
    logic [15:0]           r_q;
    logic                  r_qv;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.slot[AW-1:0]] <= i_wr.data;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.slot[AW-1:0]] <= 1'b1;
            end
            if (i_re) begin
                r_qv <= r_valid[i_raddr[AW-1:0]];
            end
        end
    end

    assign o_rdata = r_qv ? r_q : ppmsf_pkg::SLOT_RST_VALUE;

endmodule

`default_nettype wire

@@ rtl/core/ppmsf_frame_ctl.sv @@
// Frame tracking: interval measure, sync detection, slot pointer and pulse count.
`default_nettype none

module ppmsf_frame_ctl #(
    parameter int unsigned SLOT_COUNT = 12
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ppmsf_pkg::t_cfg     i_cfg,
    input  wire                 i_edge,
    input  wire  [31:0]         i_timestamp_us,
    output ppmsf_pkg::t_slot_wr o_wr,
    output ppmsf_pkg::t_status  o_edge,
    output logic [3:0]          o_cur_pulses,
    output logic                o_cur_synced
);

    logic [31:0] r_prev;
    logic [3:0]  r_next_slot;
    logic        r_sync;
    logic [3:0]  r_pulses;

    logic [31:0] interval;
    logic        is_sync;
    logic        in_valid;
    logic        slot_in_store;
    logic [3:0]  slot_inc;
    logic [3:0]  n_next_slot;
    logic        n_sync;
    logic [3:0]  n_pulses;
    logic [15:0] sat_val;

    always_comb begin
        interval      = i_timestamp_us - r_prev;
        sat_val       = (interval[31:16] != '0) ? 16'hFFFF : interval[15:0];
        is_sync       = (interval > {16'd0, i_cfg.sync_low})
                     && (interval < {16'd0, i_cfg.sync_high});
        in_valid      = (interval <= {16'd0, i_cfg.valid_high})
                     && (interval >= {16'd0, i_cfg.valid_low});
        slot_in_store = ({1'b0, r_next_slot} < 5'(SLOT_COUNT));
        slot_inc      = (r_next_slot < ppmsf_pkg::CNT_MAX) ? r_next_slot + 4'd1
                                                           : r_next_slot;
        o_wr.data     = sat_val;
        o_wr.en       = 1'b0;
        o_wr.slot     = r_next_slot;
        n_next_slot   = r_next_slot;
        n_sync        = r_sync;
        n_pulses      = r_pulses;
        if (is_sync) begin
            o_wr.en     = i_edge;
            o_wr.slot   = '0;
            n_next_slot = 4'd1;
            n_pulses    = '0;
            n_sync      = 1'b1;
        end else if (r_sync) begin
            o_wr.en     = i_edge && slot_in_store;
            n_next_slot = slot_inc;
            if (in_valid && (r_pulses < ppmsf_pkg::CNT_MAX)) begin
                n_pulses = r_pulses + 4'd1;
            end
        end
        if (n_next_slot > i_cfg.channels) begin
            n_sync   = 1'b0;
            n_pulses = '0;
        end
        o_edge.value  = sat_val;
        o_edge.pulses = n_pulses;
        o_edge.synced = n_sync;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_next_slot <= '0;
            r_sync      <= 1'b0;
            r_pulses    <= '0;
        end else if (i_edge) begin
            r_prev      <= i_timestamp_us;
            r_next_slot <= n_next_slot;
            r_sync      <= n_sync;
            r_pulses    <= n_pulses;
        end
    end

    assign o_cur_pulses = r_pulses;
    assign o_cur_synced = r_sync;

endmodule

`default_nettype wire

@@ rtl/core/ppm_sum_frame_decoder.sv @@
// Top level of the PPM-sum frame decoder.
// Usage:
//   Input channel (i_valid/o_ready) carries one item per transfer: i_cmd selects
//   an edge event (timestamp in i_timestamp_us) or a read of slot i_read_slot.
//   Output channel (o_valid/i_ready) returns exactly one result per item, in
//   order: o_slot_value, o_valid_pulses, o_synced.
//   o_valid comes from the output register, fed by the read stage. One item
//   per cycle is sustained while i_ready is high; frame state lives in registers
//   set in the transfer cycle; the slot store is a 1R/1W RAM with registered read.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle;
//   indexes beyond the register list are ignored.
//   Reset (synchronous, active low) restores default windows, clears frame
//   state and marks every slot as holding 1500; no clearing pass is needed.
//   When i_ready is low, results back up into the read stage and output
//   register; o_ready drops only when both are full, and nothing is lost.
`default_nettype none

module ppm_sum_frame_decoder #(
    parameter int unsigned SLOT_COUNT = 12
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_cmd,
    input  wire  [31:0] i_timestamp_us,
    input  wire  [3:0]  i_read_slot,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [15:0] o_slot_value,
    output logic [3:0]  o_valid_pulses,
    output logic        o_synced,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data
);

    ppmsf_pkg::t_cfg      r_cfg;
    ppmsf_pkg::t_slot_wr  wr;
    ppmsf_pkg::t_status   edge_st;
    logic [3:0]           cur_pulses;
    logic                 cur_synced;
    logic [15:0]          ram_q;

    logic                 in_xfer;
    logic                 is_read;
    logic                 rd_in_store;
    logic                 s1_move;

    logic                 r_s1_v;
    logic                 r_s1_rd;
    logic                 r_s1_hit;
    ppmsf_pkg::t_status   r_s1;
    ppmsf_pkg::t_status   n_s1;

    logic                 r_o_v;
    ppmsf_pkg::t_status   r_o;

    assign s1_move     = r_s1_v && (!r_o_v || i_ready);
    assign o_ready     = !r_s1_v || s1_move;
    assign in_xfer     = i_valid && o_ready;
    assign is_read     = (i_cmd == ppmsf_pkg::CMD_READ);
    assign rd_in_store = ({1'b0, i_read_slot} < 5'(SLOT_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_low   <= ppmsf_pkg::SYNC_LOW_RST;
            r_cfg.sync_high  <= ppmsf_pkg::SYNC_HIGH_RST;
            r_cfg.valid_low  <= ppmsf_pkg::VALID_LOW_RST;
            r_cfg.valid_high <= ppmsf_pkg::VALID_HIGH_RST;
            r_cfg.channels   <= ppmsf_pkg::CHANNELS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppmsf_pkg::CFG_SYNC_LOW:   r_cfg.sync_low   <= i_cfg_data;
                ppmsf_pkg::CFG_SYNC_HIGH:  r_cfg.sync_high  <= i_cfg_data;
                ppmsf_pkg::CFG_VALID_LOW:  r_cfg.valid_low  <= i_cfg_data;
                ppmsf_pkg::CFG_VALID_HIGH: r_cfg.valid_high <= i_cfg_data;
                ppmsf_pkg::CFG_CHANNELS:   r_cfg.channels   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    ppmsf_frame_ctl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_frame_ctl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_edge         (in_xfer && !is_read),
        .i_timestamp_us (i_timestamp_us),
        .o_wr           (wr),
        .o_edge         (edge_st),
        .o_cur_pulses   (cur_pulses),
        .o_cur_synced   (cur_synced)
    );

    ppmsf_slot_ram #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_re    (in_xfer && is_read && rd_in_store),
        .i_raddr (i_read_slot),
        .o_rdata (ram_q)
    );

    always_comb begin
        if (is_read) begin
            n_s1.value  = '0;
            n_s1.pulses = cur_pulses;
            n_s1.synced = cur_synced;
        end else begin
            n_s1 = edge_st;
        end
    end

    // read stage: RAM data arrives alongside the registered status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_xfer) begin
            r_s1_v <= 1'b1;
        end else if (s1_move) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_rd  <= is_read;
            r_s1_hit <= rd_in_store;
            r_s1     <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_move) begin
            r_o_v <= 1'b1;
        end else if (i_ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o.value  <= (r_s1_rd && r_s1_hit) ? ram_q : r_s1.value;
            r_o.pulses <= r_s1.pulses;
            r_o.synced <= r_s1.synced;
        end
    end

    assign o_valid        = r_o_v;
    assign o_slot_value   = r_o.value;
    assign o_valid_pulses = r_o.pulses;
    assign o_synced       = r_o.synced;

    a_unsynced_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !r_o.synced) |-> (r_o.pulses == 4'd0))
        else $error("pulse count nonzero while out of sync");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1_v)
        else $error("accepted transfer did not reach read stage");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_move) |=> (r_s1_v && $stable(r_s1) && $stable(ram_q)))
        else $error("stalled read stage changed");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_o_v && !i_ready) |-> !o_ready)
        else $error("input accepted with pipeline full");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the PPM-sum frame decoder: random frames, reads and flow control.
`timescale 1ns / 1ps

module tb;

    localparam int SLOT_COUNT = 12;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES = 8;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        ppmsf_pkg::t_cmd cmd;
        logic [31:0]     stamp;
        logic [3:0]      slot;
    } t_pulse_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = 1'b0;
    logic [31:0] i_timestamp_us = '0;
    logic [3:0]  i_read_slot = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_slot_value;
    logic [3:0]  o_valid_pulses;
    logic        o_synced;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    ppm_sum_frame_decoder #(.SLOT_COUNT(SLOT_COUNT)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_timestamp_us (i_timestamp_us),
        .i_read_slot    (i_read_slot),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_slot_value   (o_slot_value),
        .o_valid_pulses (o_valid_pulses),
        .o_synced       (o_synced),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // decoder model state
    ppmsf_pkg::t_cfg win = '{ppmsf_pkg::SYNC_LOW_RST, ppmsf_pkg::SYNC_HIGH_RST,
                             ppmsf_pkg::VALID_LOW_RST, ppmsf_pkg::VALID_HIGH_RST,
                             ppmsf_pkg::CHANNELS_RST};
    logic [31:0] last_stamp = '0;
    logic [3:0]  slot_idx = '0;
    logic        in_sync = 1'b0;
    logic [3:0]  pulse_cnt = '0;
    logic [15:0] slot_mem [SLOT_COUNT];

    t_pulse_item        item_backlog[$];
    ppmsf_pkg::t_status expected_status[$];
    t_pulse_item        cur_item;
    ppmsf_pkg::t_status want;
    logic        offering = 1'b0;
    logic        rdy_next;
    logic [31:0] gen_stamp = '0;

    int src_idle_pct = 0;
    int dst_stall_pct = 0;
    int hold_asks = 0;
    int hold_done = 0;
    int hold_cnt = 0;
    int n_fail = 0;
    int n_checked = 0;
    int n_edges = 0;
    int n_reads = 0;
    int n_queued = 0;
    int cycles = 0;

    function automatic logic [15:0] clip16(input logic [31:0] v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void store_gap(input logic [31:0] gap);
        if (slot_idx < SLOT_COUNT) slot_mem[slot_idx] = clip16(gap);
        if (slot_idx < ppmsf_pkg::CNT_MAX) slot_idx++;
    endfunction

    function automatic void decode_item(input t_pulse_item it);
        logic [31:0]        gap;
        ppmsf_pkg::t_status r;
        if (it.cmd == ppmsf_pkg::CMD_READ) begin
            r.value = (it.slot < SLOT_COUNT) ? slot_mem[it.slot] : 16'd0;
        end else begin
            gap = it.stamp - last_stamp;
            last_stamp = it.stamp;
            if (gap > {16'd0, win.sync_low} && gap < {16'd0, win.sync_high}) begin
                slot_idx = '0;
                pulse_cnt = '0;
                store_gap(gap);
                in_sync = 1'b1;
            end else if (in_sync) begin
                store_gap(gap);
                if (gap <= {16'd0, win.valid_high} && gap >= {16'd0, win.valid_low}
                        && pulse_cnt < ppmsf_pkg::CNT_MAX)
                    pulse_cnt++;
            end
            if (slot_idx > win.channels) begin
                in_sync = 1'b0;
                pulse_cnt = '0;
            end
            r.value = clip16(gap);
        end
        r.pulses = pulse_cnt;
        r.synced = in_sync;
        expected_status.push_back(r);
    endfunction

    function automatic void queue_stamp(input logic [31:0] gap);
        gen_stamp = gen_stamp + gap;
        item_backlog.push_back('{cmd: ppmsf_pkg::CMD_EDGE, stamp: gen_stamp,
                                 slot: 4'($urandom)});
        n_queued++;
    endfunction

    function automatic void queue_read(input logic [3:0] slot);
        item_backlog.push_back('{cmd: ppmsf_pkg::CMD_READ, stamp: $urandom, slot: slot});
        n_queued++;
    endfunction

    function automatic logic [31:0] sync_gap();
        int unsigned lo;
        int unsigned hi;
        lo = 32'(win.sync_low);
        hi = 32'(win.sync_high);
        if (hi > lo + 1) return $urandom_range(hi - 1, lo + 1);
        return $urandom_range(65535);
    endfunction

    function automatic logic [31:0] channel_gap();
        int unsigned lo;
        int unsigned hi;
        int          r;
        lo = 32'(win.valid_low);
        hi = 32'(win.valid_high);
        r = $urandom_range(99);
        if (r < 70 && lo <= hi) return $urandom_range(hi, lo);
        if (r < 85) return $urandom_range(70000);
        case ($urandom_range(3))
            0: return lo - 1;
            1: return lo;
            2: return hi;
            default: return hi + 1;
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            ppmsf_pkg::CFG_SYNC_LOW:   win.sync_low = data;
            ppmsf_pkg::CFG_SYNC_HIGH:  win.sync_high = data;
            ppmsf_pkg::CFG_VALID_LOW:  win.valid_low = data;
            ppmsf_pkg::CFG_VALID_HIGH: win.valid_high = data;
            ppmsf_pkg::CFG_CHANNELS:   win.channels = data[3:0];
            default: ;
        endcase
    endtask

    task automatic program_window(input logic [15:0] sl, input logic [15:0] sh,
                                  input logic [15:0] vl, input logic [15:0] vh,
                                  input logic [3:0] ch);
        write_reg(3'(ppmsf_pkg::CFG_CHANNELS + 1 + $urandom_range(2)), 16'($urandom));
        write_reg(ppmsf_pkg::CFG_SYNC_LOW, sl);
        write_reg(ppmsf_pkg::CFG_SYNC_HIGH, sh);
        write_reg(ppmsf_pkg::CFG_VALID_LOW, vl);
        write_reg(ppmsf_pkg::CFG_VALID_HIGH, vh);
        write_reg(ppmsf_pkg::CFG_CHANNELS, {12'($urandom), ch});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (item_backlog.size() != 0 || offering || expected_status.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                decode_item(cur_item);
                if (cur_item.cmd == ppmsf_pkg::CMD_READ) n_reads++;
                else n_edges++;
                offering = 1'b0;
            end
            if (!offering && item_backlog.size() != 0
                    && $urandom_range(99) >= src_idle_pct) begin
                cur_item = item_backlog.pop_front();
                offering = 1'b1;
                i_cmd <= cur_item.cmd;
                i_timestamp_us <= cur_item.stamp;
                i_read_slot <= cur_item.slot;
            end
            i_valid <= offering;
        end
    end

    // receiver and result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_status.size() == 0) begin
                    $error("unexpected result: slot_value %0d", o_slot_value);
                    n_fail++;
                end else begin
                    want = expected_status.pop_front();
                    if (o_slot_value !== want.value) begin
                        $error("slot_value expected %0d got %0d", want.value, o_slot_value);
                        n_fail++;
                    end
                    if (o_valid_pulses !== want.pulses) begin
                        $error("valid_pulses expected %0d got %0d", want.pulses,
                               o_valid_pulses);
                        n_fail++;
                    end
                    if (o_synced !== want.synced) begin
                        $error("synced expected %0d got %0d", want.synced, o_synced);
                        n_fail++;
                    end
                    n_checked++;
                end
            end
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy_next = 1'b0;
            end else begin
                rdy_next = $urandom_range(99) >= dst_stall_pct;
            end
            i_ready <= rdy_next;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    int unsigned ph_sl [NUM_PHASES] = '{3000, 60000, 4000, 2500, 3000, 0, 65535, 3000};
    int unsigned ph_sh [NUM_PHASES] = '{21000, 65535, 12000, 30000, 21000, 1000, 0, 21000};
    int unsigned ph_vl [NUM_PHASES] = '{900, 0, 1000, 800, 900, 1000, 65535, 900};
    int unsigned ph_vh [NUM_PHASES] = '{2200, 65535, 2000, 2400, 2200, 3000, 0, 2200};
    int unsigned ph_ch [NUM_PHASES] = '{8, 15, 0, 1, 11, 5, 12, 15};
    int          idle_src [4] = '{0, 76, 0, 18};
    int          idle_dst [4] = '{0, 0, 76, 18};

    initial begin
        int target;
        int k;
        int r;
        for (int i = 0; i < SLOT_COUNT; i++) slot_mem[i] = ppmsf_pkg::SLOT_RST_VALUE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        program_window(ppmsf_pkg::SYNC_LOW_RST, ppmsf_pkg::SYNC_HIGH_RST,
                       ppmsf_pkg::VALID_LOW_RST, ppmsf_pkg::VALID_HIGH_RST,
                       ppmsf_pkg::CHANNELS_RST);

        // directed: reset contents, window edges, saturation, wrap, full-width compare
        queue_read(4'd0);
        queue_read(4'd15);
        queue_stamp(5000);
        queue_stamp(900);
        queue_stamp(2200);
        queue_stamp(899);
        queue_stamp(2201);
        queue_stamp(1500);
        queue_stamp(70000);
        queue_stamp(1000);
        queue_stamp(1200);
        queue_read(4'd6);
        queue_stamp(3000);
        queue_stamp(21000);
        queue_stamp(3001);
        queue_stamp(20999);
        queue_stamp(32'hFFFF_FFFF - gen_stamp + 1000);
        queue_stamp(32'hFFFF_F000);
        queue_stamp(32'h0001_1388);
        queue_read(4'd1);
        queue_read(4'd11);
        queue_read(4'd12);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            program_window(16'(ph_sl[ph]), 16'(ph_sh[ph]), 16'(ph_vl[ph]),
                           16'(ph_vh[ph]), 4'(ph_ch[ph]));
            src_idle_pct = idle_src[ph % 4];
            dst_stall_pct = idle_dst[ph % 4];
            target = n_queued + PHASE_ITEMS;
            while (n_queued < target) begin
                r = $urandom_range(99);
                if (r < 6) begin
                    queue_stamp($urandom);
                end else if (r < 16) begin
                    queue_read(4'($urandom_range(15)));
                end else begin
                    queue_stamp(sync_gap());
                    k = $urandom_range(win.channels + 3);
                    for (int j = 0; j < k; j++) begin
                        if ($urandom_range(9) == 0) queue_read(4'($urandom_range(15)));
                        queue_stamp(channel_gap());
                    end
                end
            end
            // long receiver hold-off while the sender keeps pushing
            if (ph == 4) hold_asks++;
        end
        drain();
        repeat (6) @(posedge i_clk);
        $display("summary: %0d edge and %0d read transfers over %0d window settings,",
                 n_edges, n_reads, NUM_PHASES + 1);
        $display("summary: %0d results compared, %0d mismatches", n_checked, n_fail);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/ppmsf_pkg.sv
rtl/core/ppmsf_slot_ram.sv
rtl/core/ppmsf_frame_ctl.sv
rtl/core/ppm_sum_frame_decoder.sv
bench/tb.sv
